[sv/kwl_pkg.sv]
`timescale 1ns / 1ps

package kwl_pkg;

    // Token kinds as they appear on m_token_kind.
    localparam logic [3:0] KIND_INT     = 4'd0;
    localparam logic [3:0] KIND_IDENT   = 4'd1;
    localparam logic [3:0] KIND_NUMBER  = 4'd2;
    localparam logic [3:0] KIND_ASSIGN  = 4'd3;
    localparam logic [3:0] KIND_PLUS    = 4'd4;
    localparam logic [3:0] KIND_MINUS   = 4'd5;
    localparam logic [3:0] KIND_IF      = 4'd6;
    localparam logic [3:0] KIND_LBRACE  = 4'd7;
    localparam logic [3:0] KIND_RBRACE  = 4'd8;
    localparam logic [3:0] KIND_SEMI    = 4'd9;
    localparam logic [3:0] KIND_UNKNOWN = 4'd10;
    localparam logic [3:0] KIND_END     = 4'd11;

    // Scan modes.
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_WORD   = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;        // input word accepted, capture it
        logic in_replay;    // controller is replaying stored text
        logic replay_fire;  // load one replayed character into the output register
        logic tail_fire;    // perform the closing action of the item
    } kwl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_flush;   // the word on the input ends a pending token
        logic replay_last;  // replay index is at the last stored character
        logic tail_emits;   // the closing action produces a result
        logic out_free;     // output register can take a result this cycle
    } kwl_stat_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c inside {8'h20, [8'h09:8'h0D]});
    endfunction

    function automatic logic [3:0] symbol_kind(input logic [7:0] c);
        logic [3:0] k;
        case (c)
            8'h3D:   k = KIND_ASSIGN;
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h3B:   k = KIND_SEMI;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

[sv/kwl_ctrl.sv]
`timescale 1ns / 1ps

module kwl_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  kwl_pkg::kwl_stat_t stat,
    output kwl_pkg::kwl_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_REPLAY = 2'd1;
    localparam logic [1:0] ST_TAIL   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next      = state_reg;
        s_ready         = 1'b0;
        cmd.latch       = 1'b0;
        cmd.in_replay   = 1'b0;
        cmd.replay_fire = 1'b0;
        cmd.tail_fire   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = stat.need_flush ? ST_REPLAY : ST_TAIL;
                end
            end
            ST_REPLAY: begin
                cmd.in_replay   = 1'b1;
                cmd.replay_fire = stat.out_free;
                if (stat.out_free && stat.replay_last) begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: begin
                cmd.tail_fire = !stat.tail_emits || stat.out_free;
                if (cmd.tail_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/kwl_datapath.sv]
`timescale 1ns / 1ps

module kwl_datapath #(
    parameter int MAX_TEXT_LEN = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         s_char_byte,
    input  logic               s_end_of_input,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_token_kind,
    output logic [7:0]         m_text_char,
    output logic               m_token_done,
    output logic               m_run_done,
    input  kwl_pkg::kwl_cmd_t  cmd,
    output kwl_pkg::kwl_stat_t stat
);

    localparam int DEPTH = MAX_TEXT_LEN - 1;
    localparam int CW    = $clog2(MAX_TEXT_LEN);
    localparam int AW    = $clog2(DEPTH);

    // Text store, one write port and one registered read port.
    logic [7:0] text_mem [DEPTH];
    logic [7:0] rd_data_reg;

    logic [1:0]    mode_reg, mode_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;

    // Latched input word and the first three stored characters for keyword matching.
    logic [7:0] char_reg;
    logic       eoi_reg;
    logic [7:0] c0_reg, c1_reg, c2_reg;

    logic       mvalid_reg, mvalid_next;
    logic [3:0] kind_reg, kind_next;
    logic [7:0] text_reg, text_next;
    logic       tdone_reg, tdone_next;
    logic       rdone_reg, rdone_next;

    logic          cont_in, cont_lat;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [3:0]    pend_kind;
    logic          out_free;

    always_comb begin
        cont_in = ((mode_reg == kwl_pkg::MODE_WORD) &&
                   (kwl_pkg::is_letter(s_char_byte) || kwl_pkg::is_digit(s_char_byte))) ||
                  ((mode_reg == kwl_pkg::MODE_NUMBER) && kwl_pkg::is_digit(s_char_byte));
        cont_lat = ((mode_reg == kwl_pkg::MODE_WORD) &&
                    (kwl_pkg::is_letter(char_reg) || kwl_pkg::is_digit(char_reg))) ||
                   ((mode_reg == kwl_pkg::MODE_NUMBER) && kwl_pkg::is_digit(char_reg));

        out_free = !mvalid_reg || m_ready;

        stat.need_flush  = (mode_reg != kwl_pkg::MODE_IDLE) && (s_end_of_input || !cont_in);
        stat.replay_last = (CW'(idx_reg) == count_reg - CW'(1));
        stat.tail_emits  = eoi_reg || (!cont_lat && !kwl_pkg::is_space(char_reg) &&
                           !kwl_pkg::is_letter(char_reg) && !kwl_pkg::is_digit(char_reg));
        stat.out_free    = out_free;

        if (mode_reg == kwl_pkg::MODE_NUMBER) begin
            pend_kind = kwl_pkg::KIND_NUMBER;
        end else if (count_reg == CW'(3) && c0_reg == 8'h69 && c1_reg == 8'h6E &&
                     c2_reg == 8'h74) begin
            pend_kind = kwl_pkg::KIND_INT;
        end else if (count_reg == CW'(2) && c0_reg == 8'h69 && c1_reg == 8'h66) begin
            pend_kind = kwl_pkg::KIND_IF;
        end else begin
            pend_kind = kwl_pkg::KIND_IDENT;
        end

        // Replay index; the read address follows it so the next character is ready.
        idx_next = idx_reg;
        if (!cmd.in_replay) begin
            idx_next = '0;
        end else if (cmd.replay_fire) begin
            idx_next = stat.replay_last ? '0 : idx_reg + AW'(1);
        end

        mode_next   = mode_reg;
        count_next  = count_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;
        mvalid_next = mvalid_reg && !m_ready;
        kind_next   = kind_reg;
        text_next   = text_reg;
        tdone_next  = tdone_reg;
        rdone_next  = rdone_reg;

        if (cmd.replay_fire) begin
            mvalid_next = 1'b1;
            kind_next   = pend_kind;
            text_next   = rd_data_reg;
            tdone_next  = stat.replay_last;
            rdone_next  = stat.replay_last && !stat.tail_emits;
        end

        if (cmd.tail_fire) begin
            if (eoi_reg) begin
                mode_next   = kwl_pkg::MODE_IDLE;
                count_next  = '0;
                mvalid_next = 1'b1;
                kind_next   = kwl_pkg::KIND_END;
                text_next   = 8'h00;
                tdone_next  = 1'b1;
                rdone_next  = 1'b1;
            end else if (cont_lat) begin
                if (count_reg < CW'(DEPTH)) begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[AW-1:0];
                    count_next = count_reg + CW'(1);
                end
            end else begin
                mode_next  = kwl_pkg::MODE_IDLE;
                count_next = '0;
                if (kwl_pkg::is_letter(char_reg) || kwl_pkg::is_digit(char_reg)) begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    count_next = CW'(1);
                    mode_next  = kwl_pkg::is_letter(char_reg) ? kwl_pkg::MODE_WORD
                                                              : kwl_pkg::MODE_NUMBER;
                end else if (!kwl_pkg::is_space(char_reg)) begin
                    mvalid_next = 1'b1;
                    kind_next   = kwl_pkg::symbol_kind(char_reg);
                    text_next   = char_reg;
                    tdone_next  = 1'b1;
                    rdone_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            text_mem[wr_addr] <= char_reg;
        end
        rd_data_reg <= text_mem[idx_next];
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            char_reg <= s_char_byte;
            eoi_reg  <= s_end_of_input;
        end
        if (wr_en) begin
            if (wr_addr == AW'(0)) begin
                c0_reg <= char_reg;
            end
            if (wr_addr == AW'(1)) begin
                c1_reg <= char_reg;
            end
            if (wr_addr == AW'(2)) begin
                c2_reg <= char_reg;
            end
        end
        kind_reg  <= kind_next;
        text_reg  <= text_next;
        tdone_reg <= tdone_next;
        rdone_reg <= rdone_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= kwl_pkg::MODE_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_valid      = mvalid_reg;
    assign m_token_kind = kind_reg;
    assign m_text_char  = text_reg;
    assign m_token_done = tdone_reg;
    assign m_run_done   = rdone_reg;

    // Idle mode holds no text, and a token in progress always holds some.
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == kwl_pkg::MODE_IDLE) |-> (count_reg == '0))
        else $error("idle scan mode with stored text");

    a_busy_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != kwl_pkg::MODE_IDLE) |-> (count_reg != '0))
        else $error("token in progress with no stored text");

    a_replay_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.replay_fire |-> (mode_reg != kwl_pkg::MODE_IDLE))
        else $error("replay while no token is pending");

    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.replay_fire && stat.replay_last) |=> (m_valid && m_token_done))
        else $error("last replayed character without token end flag");

endmodule

[sv/keyword_token_lexer.sv]
`timescale 1ns / 1ps

// Character lexer: one word on the s_ channel carries a character byte or an end
// marker, and the m_ channel gives one word per token character. Whitespace is
// skipped; words (a letter, then letters and digits) and numbers (digits) are
// collected in a text store of MAX_TEXT_LEN-1 characters, and longer text is
// consumed but not stored. When a token ends, its stored text is replayed in
// order, with m_token_done on its last character and m_run_done on the last word
// caused by the input word. A character word is accepted and then given its
// closing action, and an input word that ends a pending token first has each
// stored character replayed, since the text store has a single read port and
// the output register takes one result per cycle while m_ready does not stall
// it. The text store needs no clearing after reset, so the block accepts input
// from the first cycle out of reset.
module keyword_token_lexer #(
    parameter int MAX_TEXT_LEN = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_byte,
    input  logic       s_end_of_input,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_token_kind,
    output logic [7:0] m_text_char,
    output logic       m_token_done,
    output logic       m_run_done
);

    kwl_pkg::kwl_cmd_t  cmd;
    kwl_pkg::kwl_stat_t stat;

    // The controller sequences accept, replay and the closing action.
    kwl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath holds the scan mode, the text store and the output register.
    kwl_datapath #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_char_byte    (s_char_byte),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_text_char    (m_text_char),
        .m_token_done   (m_token_done),
        .m_run_done     (m_run_done),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

[verif/keyword_token_lexer_tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the keyword token lexer. Character words go in on
// the s_ channel, one character or one end marker per word. A local lexer
// model works out, for every accepted word, the token characters that it
// should release. The m_ channel monitor compares each released word against
// the oldest pending character, field by field.
module keyword_token_lexer_tb;

    localparam int TEXT_LEN    = 32;
    localparam int STORE_SLOTS = TEXT_LEN - 1;

    // The slowest legal run is far below this: every word releasing a full
    // token with the longest receiver stall on each character still fits
    // several times over.
    localparam int CYCLE_LIMIT = 1500000;

    // Extra cycles watched after the last expected word, to catch stray output.
    localparam int TAIL_CYCLES = 40;

    // One token character as it should appear on the m_ channel.
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] ch;
        logic       tdone;
        logic       rdone;
    } lex_char_t;

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_byte    = 8'h00;
    logic       s_end_of_input = 1'b0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic [3:0] m_token_kind;
    logic [7:0] m_text_char;
    logic       m_token_done;
    logic       m_run_done;

    // Token characters that the lexer still owes, oldest first.
    lex_char_t due_chars[$];

    // Local copy of the lexer state.
    logic [1:0] lx_mode  = kwl_pkg::MODE_IDLE;
    logic [7:0] lx_text[STORE_SLOTS];
    int         lx_count = 0;

    int fail_count  = 0;
    int cycle_count = 0;

    // Idle controls for the sender and the receiver.
    bit tx_gaps_on     = 1'b1;
    bit rx_gaps_on     = 1'b1;
    int rx_hold_cycles = 0;

    keyword_token_lexer #(
        .MAX_TEXT_LEN(TEXT_LEN)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_byte   (s_char_byte),
        .s_end_of_input(s_end_of_input),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_kind  (m_token_kind),
        .m_text_char   (m_text_char),
        .m_token_done  (m_token_done),
        .m_run_done    (m_run_done)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Lexer model
    // ------------------------------------------------------------------

    function automatic logic letter_ch(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic digit_ch(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Space plus the control range from tab through carriage return.
    function automatic logic blank_ch(input logic [7:0] c);
        return c == " " || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic void owe_char(input logic [3:0] kind, input logic [7:0] ch,
                                     input logic tdone);
        lex_char_t b;
        b.kind  = kind;
        b.ch    = ch;
        b.tdone = tdone;
        b.rdone = 1'b0;
        due_chars.push_back(b);
    endfunction

    function automatic void keep_text(input logic [7:0] c);
        // Text past the store depth is consumed but not kept.
        if (lx_count < STORE_SLOTS) begin
            lx_text[lx_count] = c;
            lx_count++;
        end
    endfunction

    // Release the pending word or number, if there is one, and go idle.
    function automatic void flush_text();
        logic [3:0] kind;
        if (lx_mode == kwl_pkg::MODE_WORD) begin
            if (lx_count == 3 && lx_text[0] == "i" && lx_text[1] == "n" && lx_text[2] == "t")
                kind = kwl_pkg::KIND_INT;
            else if (lx_count == 2 && lx_text[0] == "i" && lx_text[1] == "f")
                kind = kwl_pkg::KIND_IF;
            else
                kind = kwl_pkg::KIND_IDENT;
        end else if (lx_mode == kwl_pkg::MODE_NUMBER) begin
            kind = kwl_pkg::KIND_NUMBER;
        end else begin
            lx_count = 0;
            lx_mode  = kwl_pkg::MODE_IDLE;
            return;
        end
        for (int i = 0; i < lx_count; i++)
            owe_char(kind, lx_text[i], (i + 1 == lx_count));
        lx_count = 0;
        lx_mode  = kwl_pkg::MODE_IDLE;
    endfunction

    // A character seen between tokens: skip it, open a word or number, or
    // release it as a one-character token.
    function automatic void start_token(input logic [7:0] c);
        logic [3:0] kind;
        if (blank_ch(c))
            return;
        if (letter_ch(c)) begin
            lx_mode  = kwl_pkg::MODE_WORD;
            lx_count = 0;
            keep_text(c);
            return;
        end
        if (digit_ch(c)) begin
            lx_mode  = kwl_pkg::MODE_NUMBER;
            lx_count = 0;
            keep_text(c);
            return;
        end
        case (c)
            "=":     kind = kwl_pkg::KIND_ASSIGN;
            "+":     kind = kwl_pkg::KIND_PLUS;
            "-":     kind = kwl_pkg::KIND_MINUS;
            "{":     kind = kwl_pkg::KIND_LBRACE;
            "}":     kind = kwl_pkg::KIND_RBRACE;
            ";":     kind = kwl_pkg::KIND_SEMI;
            default: kind = kwl_pkg::KIND_UNKNOWN;
        endcase
        owe_char(kind, c, 1'b1);
    endfunction

    // Advance the model by one accepted word and queue what it releases.
    function automatic void scan_char(input logic [7:0] c, input logic eoi);
        int        n_prior;
        lex_char_t last;
        n_prior = due_chars.size();
        if (eoi) begin
            flush_text();
            owe_char(kwl_pkg::KIND_END, 8'h00, 1'b1);
        end else if (lx_mode == kwl_pkg::MODE_WORD) begin
            if (letter_ch(c) || digit_ch(c)) begin
                keep_text(c);
            end else begin
                flush_text();
                start_token(c);
            end
        end else if (lx_mode == kwl_pkg::MODE_NUMBER) begin
            if (digit_ch(c)) begin
                keep_text(c);
            end else begin
                flush_text();
                start_token(c);
            end
        end else begin
            start_token(c);
        end
        // The last character released by this word closes the run.
        if (due_chars.size() > n_prior) begin
            last = due_chars.pop_back();
            last.rdone = 1'b1;
            due_chars.push_back(last);
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one word after a random gap and wait until it is accepted. If the
    // gap is zero, valid stays high and only the payload moves.
    task automatic send_word(input logic [7:0] c, input logic eoi);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 14) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_char_byte    <= c;
        s_end_of_input <= eoi;
        do @(posedge aclk); while (!s_ready);
        scan_char(c, eoi);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    // Drop valid so that nothing is offered while the bench waits elsewhere.
    task automatic idle_tx();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'(8'h61 + r) : 8'(8'h41 + r - 26);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_blank();
        int r;
        r = $urandom_range(8, 13);
        return (r == 8) ? 8'h20 : 8'(r);
    endfunction

    // Send one random lexical unit. Most are well-formed tokens with random
    // text; the rest are blanks, raw bytes and end markers. n_sent counts the
    // words that the lexer does not simply skip.
    task automatic send_rand_token(output int n_sent);
        int    pick;
        int    len;
        bit    spaced;
        string syms;
        syms   = "=+-{};";
        n_sent = 0;
        spaced = 1'b0;
        pick   = $urandom_range(0, 99);
        if (pick < 30) begin
            // A word, now and then longer than the text store.
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 8);
            send_word(rand_letter(), 1'b0);
            for (int i = 1; i < len; i++)
                send_word(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter(), 1'b0);
            n_sent = len;
            spaced = 1'b1;
        end else if (pick < 42) begin
            if ($urandom_range(0, 1)) begin
                send_text("int");
                n_sent = 3;
            end else begin
                send_text("if");
                n_sent = 2;
            end
            spaced = 1'b1;
        end else if (pick < 56) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                send_word(rand_digit(), 1'b0);
            n_sent = len;
            spaced = 1'b1;
        end else if (pick < 76) begin
            send_word(syms[$urandom_range(0, 5)], 1'b0);
            n_sent = 1;
        end else if (pick < 86) begin
            send_word(rand_blank(), 1'b0);
        end else if (pick < 96) begin
            send_word(8'($urandom_range(0, 255)), 1'b0);
            n_sent = 1;
        end else begin
            send_word(8'($urandom_range(0, 255)), 1'b1);
            n_sent = 1;
        end
        // Half of the words and numbers end on a blank, the rest run straight
        // into whatever comes next.
        if (spaced && $urandom_range(0, 1))
            send_word(rand_blank(), 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------

    // Each result word is preceded by a random stall, or by one long hold when
    // a test asks for it. The hold is counted here, independently of the sender.
    always begin : rx_proc
        int stall;
        @(negedge aclk);
        if (rx_hold_cycles > 0) begin
            stall          = rx_hold_cycles;
            rx_hold_cycles = 0;
        end else begin
            stall = rx_gaps_on ? $urandom_range(0, 14) : 0;
        end
        if (stall > 0) begin
            m_ready <= 1'b0;
            repeat (stall) @(negedge aclk);
        end
        m_ready <= 1'b1;
        do @(posedge aclk); while (!(m_valid && m_ready));
    end

    task automatic report_mismatch(input string msg);
        // Only the first failures are printed; all of them are counted.
        if (fail_count < 40)
            $display("MISMATCH at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_result();
        lex_char_t want;
        if (due_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected word kind %0d char %02h",
                                      m_token_kind, m_text_char));
        end else begin
            want = due_chars.pop_front();
            if (m_token_kind !== want.kind)
                report_mismatch($sformatf("token_kind %0d, expected %0d",
                                          m_token_kind, want.kind));
            if (m_text_char !== want.ch)
                report_mismatch($sformatf("text_char %02h, expected %02h",
                                          m_text_char, want.ch));
            if (m_token_done !== want.tdone)
                report_mismatch($sformatf("token_done %0b, expected %0b",
                                          m_token_done, want.tdone));
            if (m_run_done !== want.rdone)
                report_mismatch($sformatf("run_done %0b, expected %0b",
                                          m_run_done, want.rdone));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_result();
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words still due",
                     cycle_count, due_chars.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Both keywords, an identifier ended by a symbol, a number ended by a
    // letter, every symbol, high bytes that end a word or stand alone, blanks,
    // the null byte, and an end marker that flushes a pending word.
    task automatic check_keywords_and_symbols();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        send_text("int if{x9=07q+-};");
        send_word(8'h80, 1'b0);
        send_word("z", 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h09, 1'b0);
        send_word(8'h0D, 1'b0);
        send_word(8'h00, 1'b0);
        send_word("k", 1'b0);
        send_word(8'hA5, 1'b1);
    endtask

    // A word and a number longer than the text store: only the first
    // characters come back, and the tail is swallowed up to the terminator.
    task automatic check_overlong_text();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b1;
        send_word("W", 1'b0);
        for (int i = 1; i < STORE_SLOTS + 4; i++)
            send_word((i % 3 == 0) ? rand_digit() : rand_letter(), 1'b0);
        send_word(";", 1'b0);
        for (int i = 0; i < STORE_SLOTS + 2; i++)
            send_word(rand_digit(), 1'b0);
        send_word(8'h5A, 1'b1);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering words back to back, so the lexer fills and stalls its input.
    task automatic check_output_stall();
        int n;
        tx_gaps_on     = 1'b0;
        rx_gaps_on     = 1'b0;
        rx_hold_cycles = 300;
        for (int i = 0; i < 40; i++)
            send_rand_token(n);
        idle_tx();
        wait (due_chars.size() == 0);
    endtask

    // Random token streams. Idle behavior on each side is redrawn in phases,
    // so some stretches run with no gaps at all.
    task automatic check_random_text(input int n_items);
        int counted;
        int phase_left;
        int n;
        counted    = 0;
        phase_left = 0;
        while (counted < n_items) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(10, 40);
                tx_gaps_on = ($urandom_range(0, 3) != 0);
                rx_gaps_on = ($urandom_range(0, 3) != 0);
            end
            send_rand_token(n);
            counted += n;
            phase_left--;
        end
    endtask

    // The sender stops until every owed word has come back, then resumes.
    task automatic check_drain_pause();
        idle_tx();
        wait (due_chars.size() == 0);
        send_text("if x=1;");
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        check_keywords_and_symbols();
        check_overlong_text();
        check_output_stall();
        check_random_text(110);
        check_drain_pause();
        check_random_text(110);

        idle_tx();
        wait (due_chars.size() == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
